// ----- rtl/eesh_pkg.sv -----
// ----------------------------------------------------------------------------
// eesh_pkg
// Shared types, codes and constants of the event energy histogrammer.
// ----------------------------------------------------------------------------
package eesh_pkg;

    localparam int NUM_BINS_DEF = 2048;
    localparam int SUM_W        = 24;
    localparam int CNT_W        = 32;
    localparam int BW_W         = 13;
    localparam int TIME_W       = 24;
    localparam int EID_W        = 32;
    localparam int ENE_W        = 20;
    localparam int IDX_W        = 12;
    localparam int CFG_W        = 24;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        REQ_HIT  = 2'd0,
        REQ_EOD  = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } eesh_req_t;

    typedef enum logic [1:0] {
        CFG_WINDOW_LOW  = 2'd0,
        CFG_WINDOW_HIGH = 2'd1,
        CFG_BIN_WIDTH   = 2'd2,
        CFG_UNUSED      = 2'd3
    } eesh_cfg_idx_t;

    // one command from the front to the back, one per input word
    typedef struct packed {
        logic             close;
        logic [SUM_W-1:0] sum_in;
        logic [SUM_W-1:0] sum_out;
        logic             is_read;
        logic             sel_out;
        logic [IDX_W-1:0] idx;
        logic             accepted;
    } eesh_cmd_t;

    typedef struct packed {
        logic clearing;
    } eesh_back_status_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_PLANE,
        BK_DIV,
        BK_BIN,
        BK_RMW,
        BK_RD_WAIT,
        BK_RESULT
    } eesh_back_state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ----- rtl/eesh_if.sv -----
// ----------------------------------------------------------------------------
// eesh_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface eesh_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [eesh_pkg::EID_W-1:0]  event_id;
    logic [eesh_pkg::ENE_W-1:0]  deposit_energy;
    logic [eesh_pkg::TIME_W-1:0] hit_time;
    logic                      in_plane;
    logic                      hist_select;
    logic [eesh_pkg::IDX_W-1:0]  bin_index;

    modport source (output valid, req_type, event_id, deposit_energy, hit_time,
                    in_plane, hist_select, bin_index, input ready);
    modport sink   (input valid, req_type, event_id, deposit_energy, hit_time,
                    in_plane, hist_select, bin_index, output ready);
endinterface

interface eesh_out_if;
    logic                       valid;
    logic                       ready;
    logic [eesh_pkg::CNT_W-1:0] bin_count;
    logic [eesh_pkg::CNT_W-1:0] entries_in;
    logic [eesh_pkg::CNT_W-1:0] entries_out;
    logic                       hit_accepted;
    logic                       event_closed;

    modport source (output valid, bin_count, entries_in, entries_out, hit_accepted,
                    event_closed, input ready);
    modport sink   (input valid, bin_count, entries_in, entries_out, hit_accepted,
                    event_closed, output ready);
endinterface

// ----- rtl/event_energy_sum_histogrammer_core.sv -----
// Event energy histogrammer. Hits are accepted, windowed and summed per plane
// in the front end; a two-word queue decouples it from the back end, which
// executes one word at a time. A hit, read or end of data that closes nothing
// goes from idle to the result state (a read of an in-range bin passes a read
// wait state between them). Closing an event runs, per nonzero plane sum,
// plane select, a bit-serial divide, binning and a histogram read-modify-write
// (an overflow count instead when out of range); that divider sets the
// sustained rate for event-closing words. After reset the back end clears
// both histogram memories, one bin per cycle; no request word is accepted in
// that time, configuration writes are.
// ----------------------------------------------------------------------------
// event_energy_sum_histogrammer_core
// Top level: configuration registers, front end, command queue, back end.
// ----------------------------------------------------------------------------
module event_energy_sum_histogrammer_core #(
    parameter int NUM_BINS = eesh_pkg::NUM_BINS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    eesh_in_if.sink                    in_ch,
    eesh_out_if.source                 out_ch,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [eesh_pkg::CFG_W-1:0] cfg_data
);
    import eesh_pkg::*;

    logic [TIME_W-1:0] window_low_reg, window_high_reg;
    logic [BW_W-1:0]   bin_width_reg;
    logic              push, pop, not_empty, not_full, push_ok;
    eesh_cmd_t         push_cmd, head;
    eesh_back_status_t back_status;

    assign push_ok = not_full && !back_status.clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_low_reg  <= '0;
            window_high_reg <= TIME_W'(50000);
            bin_width_reg   <= BW_W'(10);
        end
        else if (cfg_we)
        begin
            case (eesh_cfg_idx_t'(cfg_index))
                CFG_WINDOW_LOW:  window_low_reg  <= cfg_data[TIME_W-1:0];
                CFG_WINDOW_HIGH: window_high_reg <= cfg_data[TIME_W-1:0];
                CFG_BIN_WIDTH:   bin_width_reg   <= cfg_data[BW_W-1:0];
                default:         ;
            endcase
        end
    end

    eesh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .push_ok     (push_ok),
        .window_low  (window_low_reg),
        .window_high (window_high_reg),
        .push        (push),
        .cmd         (push_cmd)
    );

    eesh_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .not_full  (not_full)
    );

    eesh_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .bin_width (bin_width_reg),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .status    (back_status),
        .out_ch    (out_ch)
    );

endmodule

// ----- rtl/eesh_front.sv -----
// ----------------------------------------------------------------------------
// eesh_front
// Accepts request words, applies the time window, builds plane sums and
// issues one command per word to the back end.
// ----------------------------------------------------------------------------
module eesh_front (
    input  logic                        clk,
    input  logic                        rst_n,
    eesh_in_if.sink                     in_ch,
    input  logic                        push_ok,
    input  logic [eesh_pkg::TIME_W-1:0] window_low,
    input  logic [eesh_pkg::TIME_W-1:0] window_high,
    output logic                        push,
    output eesh_pkg::eesh_cmd_t         cmd
);
    import eesh_pkg::*;

    logic [EID_W-1:0] current_event_reg, current_event_next;
    logic             event_open_reg, event_open_next;
    logic [SUM_W-1:0] sum_in_reg, sum_in_next;
    logic [SUM_W-1:0] sum_out_reg, sum_out_next;
    logic             in_window;
    logic [SUM_W-1:0] base_sum;
    logic [SUM_W:0]   add_sum;
    logic [SUM_W-1:0] sat_sum;

    assign in_ch.ready = push_ok;
    assign in_window = (in_ch.hit_time >= window_low) && (in_ch.hit_time <= window_high);

    always_comb
    begin
        current_event_next = current_event_reg;
        event_open_next    = event_open_reg;
        sum_in_next        = sum_in_reg;
        sum_out_next       = sum_out_reg;
        push               = 1'b0;
        cmd                = '0;
        base_sum           = '0;
        add_sum            = '0;
        sat_sum            = '0;
        if (in_ch.valid && push_ok)
        begin
            push = 1'b1;
            case (eesh_req_t'(in_ch.req_type))
                REQ_HIT:
                begin
                    cmd.close   = event_open_reg && (in_ch.event_id != current_event_reg);
                    cmd.sum_in  = sum_in_reg;
                    cmd.sum_out = sum_out_reg;
                    cmd.accepted = in_window;
                    // drop the old sums when this hit closes the open event
                    if (cmd.close)
                    begin
                        sum_in_next  = '0;
                        sum_out_next = '0;
                    end
                    base_sum = in_ch.in_plane ? sum_in_next : sum_out_next;
                    add_sum  = {1'b0, base_sum} + (SUM_W+1)'(in_ch.deposit_energy);
                    sat_sum  = add_sum[SUM_W] ? SUM_MAX : add_sum[SUM_W-1:0];
                    if (in_window)
                    begin
                        if (in_ch.in_plane)
                            sum_in_next = sat_sum;
                        else
                            sum_out_next = sat_sum;
                    end
                    current_event_next = in_ch.event_id;
                    event_open_next    = 1'b1;
                end
                REQ_EOD:
                begin
                    cmd.close       = event_open_reg;
                    cmd.sum_in      = sum_in_reg;
                    cmd.sum_out     = sum_out_reg;
                    sum_in_next     = '0;
                    sum_out_next    = '0;
                    event_open_next = 1'b0;
                end
                REQ_READ:
                begin
                    cmd.is_read = 1'b1;
                    cmd.sel_out = in_ch.hist_select;
                    cmd.idx     = in_ch.bin_index;
                end
                default:
                begin
                    cmd = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_event_reg <= '0;
            event_open_reg    <= 1'b0;
            sum_in_reg        <= '0;
            sum_out_reg       <= '0;
        end
        else
        begin
            current_event_reg <= current_event_next;
            event_open_reg    <= event_open_next;
            sum_in_reg        <= sum_in_next;
            sum_out_reg       <= sum_out_next;
        end
    end

endmodule

// ----- rtl/eesh_fifo.sv -----
// ----------------------------------------------------------------------------
// eesh_fifo
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module eesh_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  eesh_pkg::eesh_cmd_t push_data,
    input  logic                pop,
    output eesh_pkg::eesh_cmd_t head,
    output logic                not_empty,
    output logic                not_full
);
    import eesh_pkg::*;

    eesh_cmd_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign not_full  = (count_reg != 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/eesh_back.sv -----
// ----------------------------------------------------------------------------
// eesh_back
// Executes commands: bit-serial binning divide, histogram update and
// readback, entry counters, result register.
// ----------------------------------------------------------------------------
module eesh_back #(
    parameter int NUM_BINS = eesh_pkg::NUM_BINS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [eesh_pkg::BW_W-1:0]   bin_width,
    input  eesh_pkg::eesh_cmd_t         head,
    input  logic                        not_empty,
    output logic                        pop,
    output eesh_pkg::eesh_back_status_t status,
    eesh_out_if.source                  out_ch
);
    import eesh_pkg::*;

    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [SUM_W:0]   NB_Q   = (SUM_W+1)'(NUM_BINS);
    localparam logic [16:0]      NB_IDX = 17'(NUM_BINS);
    localparam logic [AW-1:0]    LAST   = AW'(NUM_BINS - 1);
    localparam logic [4:0]       DIV_LAST = 5'(SUM_W - 1);

    logic [CNT_W-1:0] hist_in_mem  [NUM_BINS];
    logic [CNT_W-1:0] hist_out_mem [NUM_BINS];
    logic [CNT_W-1:0] rd_in_reg, rd_out_reg;

    eesh_back_state_t state_reg, state_next;
    eesh_cmd_t        cmd_reg, cmd_next;
    logic             plane_reg, plane_next;
    logic             filled_reg, filled_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [SUM_W-1:0] dsum_reg, dsum_next;
    logic [SUM_W-1:0] quot_reg, quot_next;
    logic [BW_W-1:0]  rem_reg, rem_next;
    logic [4:0]       bit_reg, bit_next;
    logic [CNT_W-1:0] bin_reg, bin_next;
    logic [CNT_W-1:0] ovf_in_reg, ovf_in_next, ovf_out_reg, ovf_out_next;
    logic [CNT_W-1:0] cnt_in_reg, cnt_in_next, cnt_out_reg, cnt_out_next;
    logic             ovalid_reg, ovalid_next;
    logic [CNT_W-1:0] obin_reg, obin_next, oin_reg, oin_next, oout_reg, oout_next;
    logic             oacc_reg, oacc_next, oclosed_reg, oclosed_next;

    logic [BW_W-1:0]  w;
    logic [BW_W:0]    rem_sh;
    logic             ge;
    logic [SUM_W-1:0] plane_sum;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [CNT_W-1:0] wr_data;
    logic             we_in, we_out;

    assign w       = (bin_width == '0) ? BW_W'(1) : bin_width;
    assign rem_sh  = {rem_reg, dsum_reg[SUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, w});
    assign plane_sum = plane_reg ? cmd_reg.sum_out : cmd_reg.sum_in;
    assign rd_addr = (state_reg == BK_IDLE) ? AW'(head.idx) : AW'(quot_reg);
    assign wr_addr = (state_reg == BK_CLEAR) ? clr_reg : AW'(quot_reg);
    assign wr_data = (state_reg == BK_CLEAR) ? '0
                   : sat_inc(plane_reg ? rd_out_reg : rd_in_reg);
    assign we_in   = (state_reg == BK_CLEAR) || ((state_reg == BK_RMW) && !plane_reg);
    assign we_out  = (state_reg == BK_CLEAR) || ((state_reg == BK_RMW) && plane_reg);

    assign status.clearing = (state_reg == BK_CLEAR);

    assign out_ch.valid        = ovalid_reg;
    assign out_ch.bin_count    = obin_reg;
    assign out_ch.entries_in   = oin_reg;
    assign out_ch.entries_out  = oout_reg;
    assign out_ch.hit_accepted = oacc_reg;
    assign out_ch.event_closed = oclosed_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        plane_next   = plane_reg;
        filled_next  = filled_reg;
        clr_next     = clr_reg;
        dsum_next    = dsum_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        bit_next     = bit_reg;
        bin_next     = bin_reg;
        ovf_in_next  = ovf_in_reg;
        ovf_out_next = ovf_out_reg;
        cnt_in_next  = cnt_in_reg;
        cnt_out_next = cnt_out_reg;
        ovalid_next  = ovalid_reg && !out_ch.ready;
        obin_next    = obin_reg;
        oin_next     = oin_reg;
        oout_next    = oout_reg;
        oacc_next    = oacc_reg;
        oclosed_next = oclosed_reg;
        pop          = 1'b0;
        case (state_reg)
            BK_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST)
                    state_next = BK_IDLE;
            end
            BK_IDLE:
            begin
                if (not_empty)
                begin
                    pop         = 1'b1;
                    cmd_next    = head;
                    plane_next  = 1'b0;
                    filled_next = 1'b0;
                    bin_next    = '0;
                    if (head.close)
                        state_next = BK_PLANE;
                    else if (head.is_read && (17'(head.idx) < NB_IDX))
                        state_next = BK_RD_WAIT;
                    else
                    begin
                        if (head.is_read && (17'(head.idx) == NB_IDX))
                            bin_next = head.sel_out ? ovf_out_reg : ovf_in_reg;
                        state_next = BK_RESULT;
                    end
                end
            end
            BK_PLANE:
            begin
                if (plane_sum != '0)
                begin
                    filled_next = 1'b1;
                    dsum_next   = plane_sum;
                    quot_next   = '0;
                    rem_next    = '0;
                    bit_next    = '0;
                    state_next  = BK_DIV;
                end
                else if (!plane_reg)
                    plane_next = 1'b1;
                else
                    state_next = BK_RESULT;
            end
            BK_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                rem_next  = ge ? BW_W'(rem_sh - {1'b0, w}) : rem_sh[BW_W-1:0];
                quot_next = {quot_reg[SUM_W-2:0], ge};
                dsum_next = {dsum_reg[SUM_W-2:0], 1'b0};
                bit_next  = bit_reg + 1'b1;
                if (bit_reg == DIV_LAST)
                    state_next = BK_BIN;
            end
            BK_BIN:
            begin
                if ({1'b0, quot_reg} >= NB_Q)
                begin
                    if (plane_reg)
                    begin
                        ovf_out_next = sat_inc(ovf_out_reg);
                        cnt_out_next = sat_inc(cnt_out_reg);
                        state_next   = BK_RESULT;
                    end
                    else
                    begin
                        ovf_in_next = sat_inc(ovf_in_reg);
                        cnt_in_next = sat_inc(cnt_in_reg);
                        plane_next  = 1'b1;
                        state_next  = BK_PLANE;
                    end
                end
                else
                    state_next = BK_RMW;
            end
            BK_RMW:
            begin
                if (plane_reg)
                begin
                    cnt_out_next = sat_inc(cnt_out_reg);
                    state_next   = BK_RESULT;
                end
                else
                begin
                    cnt_in_next = sat_inc(cnt_in_reg);
                    plane_next  = 1'b1;
                    state_next  = BK_PLANE;
                end
            end
            BK_RD_WAIT:
            begin
                bin_next   = cmd_reg.sel_out ? rd_out_reg : rd_in_reg;
                state_next = BK_RESULT;
            end
            BK_RESULT:
            begin
                // hold until the result register is free
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next  = 1'b1;
                    obin_next    = bin_reg;
                    oin_next     = cnt_in_reg;
                    oout_next    = cnt_out_reg;
                    oacc_next    = cmd_reg.accepted;
                    oclosed_next = filled_reg;
                    state_next   = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we_in)
            hist_in_mem[wr_addr] <= wr_data;
        rd_in_reg <= hist_in_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_out)
            hist_out_mem[wr_addr] <= wr_data;
        rd_out_reg <= hist_out_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        dsum_reg    <= dsum_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        bin_reg     <= bin_next;
        obin_reg    <= obin_next;
        oin_reg     <= oin_next;
        oout_reg    <= oout_next;
        oacc_reg    <= oacc_next;
        oclosed_reg <= oclosed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_CLEAR;
            plane_reg   <= 1'b0;
            filled_reg  <= 1'b0;
            clr_reg     <= '0;
            bit_reg     <= '0;
            ovf_in_reg  <= '0;
            ovf_out_reg <= '0;
            cnt_in_reg  <= '0;
            cnt_out_reg <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            plane_reg   <= plane_next;
            filled_reg  <= filled_next;
            clr_reg     <= clr_next;
            bit_reg     <= bit_next;
            ovf_in_reg  <= ovf_in_next;
            ovf_out_reg <= ovf_out_next;
            cnt_in_reg  <= cnt_in_next;
            cnt_out_reg <= cnt_out_next;
            ovalid_reg  <= ovalid_next;
        end
    end

endmodule

// ----- rtl/eesh_checker.sv -----
// ----------------------------------------------------------------------------
// eesh_checker
// Port-level checks of the histogrammer, bound to the top level.
// ----------------------------------------------------------------------------
module eesh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] bin_count,
    input logic [31:0] entries_in,
    input logic        hit_accepted,
    input logic        event_closed
);
    logic [3:0]  pending_reg;
    logic [31:0] last_in_reg;
    logic        in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            last_in_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {3'b0, in_acc} - {3'b0, out_acc};
            if (out_acc)
                last_in_reg <= entries_in;
        end
    end

    // a result word always has an accepted request behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 4'd0))
        else $error("result word without a request");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bin_count))
        else $error("result word dropped while stalled");

    a_entries_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (entries_in >= last_in_reg))
        else $error("in-plane entry count went down");

    a_flags_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (hit_accepted || event_closed) |-> (bin_count == 32'd0))
        else $error("bin count on a non-read word");

endmodule

bind event_energy_sum_histogrammer_core eesh_checker u_eesh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .bin_count    (out_ch.bin_count),
    .entries_in   (out_ch.entries_in),
    .hit_accepted (out_ch.hit_accepted),
    .event_closed (out_ch.event_closed)
);
